@@ design/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int PW         = 17;

    localparam logic [PW:0]   HEAP_BYTES   = (PW + 1)'(2 * HEAP_WORDS);
    localparam logic [15:0]   MAX_REQ      = 16'hFFFB;
    localparam logic [15:0]   MARGIN_RESET = 16'd1024;
    localparam logic [15:0]   SIZE_MASK    = 16'hFFFE;

    localparam logic          CMD_ALLOC   = 1'b0;
    localparam logic          CMD_RELEASE = 1'b1;

    localparam logic          CFG_BASE_ADDR    = 1'b0;
    localparam logic          CFG_STACK_MARGIN = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_BAD_SIZE = 2'd1;
    localparam t_status ST_NO_SPACE = 2'd2;
    localparam t_status ST_IGNORED  = 2'd3;

    typedef logic [PW-1:0] t_bptr;

    function automatic logic out_of_mem(input t_bptr a);
        out_of_mem = ({1'b0, a[PW-1:1]} >= PW'(HEAP_WORDS));
    endfunction

endpackage
`default_nettype wire

@@ design/first_fit_heap_allocator.sv @@
`default_nettype none
// channel   dir  tdata                                      tuser
// s_axis    in   [15:0] req_size [31:16] block_addr          [0] cmd
//                [47:32] stack_top
// m_axis    out  [15:0] result_addr                         [1:0] status
// cfg       in   i_cfg_addr 0 base address, 1 stack_margin; i_cfg_data 16 bit
//
// one request at a time; the header memory gives one header per cycle
// allocate: walks the headers from the base address; if no free block fits, it grows
//           the heap, writing the new block's header and then a new end header
// release: reads the headers in order (the block, each merged block
//          and the header that ends the merge)
// rejected requests go straight to the output; a result waits in the output register
// reset is synchronous; the header memory is not cleared and needs no sweep
module first_fit_heap_allocator (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire                    i_cfg_addr,
    input  wire  [15:0]            i_cfg_data,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [47:0]            s_axis_tdata,   // req_size, block_addr, stack_top
    input  wire                    s_axis_tuser,   // cmd
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // result_addr
    output ffha_pkg::t_status      m_axis_tuser    // status
);
    import ffha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_RHEAD = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_GROW  = 3'd4;
    localparam logic [2:0] S_GROW2 = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [15:0] mem [HEAP_WORDS];

    logic [2:0]  r_state, n_state;
    logic        r_started, n_started;
    logic [15:0] r_base_addr, r_stack_margin;
    t_bptr       r_p, n_p;
    logic [15:0] r_hp, n_hp;
    logic [15:0] r_size, n_size;
    logic [15:0] r_need, n_need;
    logic [15:0] r_top, n_top;
    logic [15:0] r_res_addr, n_res_addr;
    t_status     r_res_status, n_res_status;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_addr, n_out_addr;
    t_status     r_out_status, n_out_status;
    logic [15:0] r_rdata;
    logic        r_rd_oob;

    logic        w_we;
    t_bptr       w_waddr;
    logic [15:0] w_wdata;

    logic        w_accept;
    logic [15:0] w_req, w_baddr, w_stop, w_base, w_hp_in, w_hdr, w_s, w_limit;
    logic [16:0] w_sum;
    logic [PW:0] w_end;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_req    = s_axis_tdata[15:0];
    assign w_baddr  = s_axis_tdata[31:16];
    assign w_stop   = s_axis_tdata[47:32];
    assign w_base   = r_base_addr & SIZE_MASK;
    assign w_hp_in  = (w_baddr - 16'd2) & SIZE_MASK;
    assign w_hdr    = r_rd_oob ? 16'd0 : r_rdata;
    assign w_s      = w_hdr & SIZE_MASK;
    assign w_sum    = {1'b0, r_size} + {1'b0, w_s};
    assign w_limit  = r_top - r_stack_margin;
    assign w_end    = {1'b0, r_p} + {2'b0, r_need} + (PW + 1)'(2);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_p          = r_p;
        n_hp         = r_hp;
        n_size       = r_size;
        n_need       = r_need;
        n_top        = r_top;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_p;
        w_wdata      = 16'd0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_top      = w_stop;
                    n_need     = ((w_req + 16'd1) & SIZE_MASK) + 16'd2;
                    n_res_addr = 16'd0;
                    if (s_axis_tuser == CMD_ALLOC) begin
                        n_p = {1'b0, w_base};
                        if (w_req == 16'd0 || w_req > MAX_REQ) begin
                            n_res_status = ST_BAD_SIZE;
                            n_state      = S_OUT;
                        end else if (!r_started) begin
                            n_started = 1'b1;
                            w_we      = !out_of_mem({1'b0, w_base});
                            w_waddr   = {1'b0, w_base};
                            n_state   = S_GROW;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        n_hp = w_hp_in;
                        n_p  = {1'b0, w_hp_in};
                        if (w_baddr == 16'd0 || !r_started ||
                            out_of_mem({1'b0, w_hp_in})) begin
                            n_res_status = ST_IGNORED;
                            n_state      = S_OUT;
                        end else begin
                            n_state = S_RHEAD;
                        end
                    end
                end
            end
            S_WALK: begin
                if (w_s == 16'd0) begin
                    n_state = S_GROW;
                end else if (w_hdr[0] && w_s >= r_need) begin
                    w_we         = 1'b1;
                    w_wdata      = w_s;
                    n_res_addr   = r_p[15:0] + 16'd2;
                    n_res_status = ST_DONE;
                    n_state      = S_OUT;
                end else begin
                    n_p = r_p + {1'b0, w_s};
                end
            end
            S_RHEAD: begin
                n_size = w_s;
                if (w_hdr[0]) begin
                    n_res_status = ST_IGNORED;
                    n_state      = S_OUT;
                end else if (w_s == 16'd0) begin
                    w_we         = 1'b1;
                    w_waddr      = {1'b0, r_hp};
                    w_wdata      = 16'd1;
                    n_res_status = ST_DONE;
                    n_state      = S_OUT;
                end else begin
                    n_p     = {1'b0, r_hp} + {1'b0, w_s};
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!w_hdr[0] || w_s == 16'd0 || w_sum > {1'b0, SIZE_MASK}) begin
                    w_we         = 1'b1;
                    w_waddr      = {1'b0, r_hp};
                    w_wdata      = r_size | 16'd1;
                    n_res_status = ST_DONE;
                    n_state      = S_OUT;
                end else begin
                    n_size = w_sum[15:0];
                    n_p    = {1'b0, r_hp} + w_sum;
                end
            end
            S_GROW: begin
                if (r_top < r_stack_margin || {1'b0, w_limit} < r_p ||
                    (w_limit - r_p[15:0]) < r_need || w_end > HEAP_BYTES) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_OUT;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = r_need;
                    n_state = S_GROW2;
                end
            end
            S_GROW2: begin
                w_we         = 1'b1;
                w_waddr      = r_p + {1'b0, r_need};
                w_wdata      = 16'd0;
                n_res_addr   = r_p[15:0] + 16'd2;
                n_res_status = ST_DONE;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_started      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_base_addr    <= 16'd0;
            r_stack_margin <= MARGIN_RESET;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_addr == CFG_BASE_ADDR) begin
                r_base_addr <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_addr == CFG_STACK_MARGIN) begin
                r_stack_margin <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_hp         <= n_hp;
        r_size       <= n_size;
        r_need       <= n_need;
        r_top        <= n_top;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    // header memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr[AW:1]] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= mem[n_p[AW:1]];
        r_rd_oob <= out_of_mem(n_p);
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !w_accept) |-> !w_we)
        else $error("header write while idle");

    a_write_in_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !out_of_mem(w_waddr))
        else $error("header write outside memory");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == 16'd0))
        else $error("failed request returns an address");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("second request taken while busy");

    a_started_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");

endmodule
`default_nettype wire
